FILE: hdl/hexld_pkg.sv
// Package for the hex text program loader: phase and event codes, character
// constants, register map and the state and result structures.
// No dependencies; every other file of the loader imports it.
package hexld_pkg;

  // Phase of the text parser, one-hot.
  typedef enum logic [2:0] {
    PH_HIGH    = 3'b001,
    PH_LOW     = 3'b010,
    PH_COMMENT = 3'b100
  } phase_t;

  // Kind of a result transaction.
  typedef enum logic [2:0] {
    EV_BYTE       = 3'd0,
    EV_END        = 3'd1,
    EV_END_CLEAR  = 3'd2,
    EV_END_REWIND = 3'd3,
    EV_TEXT_END   = 3'd4,
    EV_SYNTAX     = 3'd5,
    EV_UNEXPECTED = 3'd6
  } event_kind_t;

  // Characters with a meaning outside a byte.
  localparam logic [7:0] CH_COMMENT = 8'h23;  // '#'
  localparam logic [7:0] CH_END     = 8'h21;  // '!'
  localparam logic [7:0] CH_REWIND  = 8'h24;  // '$'
  localparam logic [7:0] CH_CLEAR   = 8'h40;  // '@'
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;

  // Memory size and line counter limits.
  localparam logic [8:0]  MEM_BYTES = 9'd256;
  localparam logic [15:0] LINE_MAX  = 16'hFFFF;
  localparam logic [15:0] LINE_FIRST = 16'd1;

  // Register map: one register, selected by bit 2 of the byte address.
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic REG_MEMORY_LIMIT = 1'b0;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  upper_nibble;
    logic [8:0]  stored_count;
    logic [15:0] line_counter;
  } state_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [7:0]  address;
    logic [7:0]  data;
    logic [8:0]  byte_count;
    logic [15:0] line_number;
  } result_t;

endpackage

FILE: hdl/hexld_if.sv
// Valid/ready channel interfaces of the hex text program loader: the
// character channel and the event channel. Depends on hexld_pkg.
interface hexld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface hexld_out_if;
  import hexld_pkg::*;
  logic        valid;
  logic        ready;
  event_kind_t event_kind;
  logic [7:0]  address;
  logic [7:0]  data;
  logic [8:0]  byte_count;
  logic [15:0] line_number;

  modport source (output valid, output event_kind, output address, output data,
                  output byte_count, output line_number, input ready);
  modport sink (input valid, input event_kind, input address, input data,
                input byte_count, input line_number, output ready);
endinterface

FILE: hdl/hexld_step.sv
// Per-character next-state and event logic of the hex text program loader.
// Purely combinational; depends on hexld_pkg.
module hexld_step (
  input  hexld_pkg::state_t  cur,
  input  logic [7:0]         char_code,
  input  logic               end_of_text,
  input  logic [8:0]         memory_limit,
  output hexld_pkg::state_t  nxt,
  output logic               has_result,
  output hexld_pkg::result_t result
);
  import hexld_pkg::*;

  logic        nib_ok;
  logic [3:0]  nib;
  logic [8:0]  limit_eff;
  logic [15:0] line_inc;

  // Hex digit decode.
  always_comb begin
    nib_ok = 1'b1;
    nib    = 4'd0;
    if (char_code >= 8'h30 && char_code <= 8'h39) begin
      nib = 4'(char_code - 8'h30);
    end else if (char_code >= 8'h61 && char_code <= 8'h66) begin
      nib = 4'(char_code - 8'h57);
    end else if (char_code >= 8'h41 && char_code <= 8'h46) begin
      nib = 4'(char_code - 8'h37);
    end else begin
      nib_ok = 1'b0;
    end
  end

  assign limit_eff = (memory_limit > MEM_BYTES) ? MEM_BYTES : memory_limit;
  assign line_inc  = (cur.line_counter != LINE_MAX) ? cur.line_counter + 16'd1
                                                    : cur.line_counter;

  always_comb begin
    nxt                = cur;
    has_result         = 1'b0;
    result.event_kind  = EV_BYTE;
    result.address     = 8'd0;
    result.data        = 8'd0;
    result.byte_count  = 9'd0;
    result.line_number = cur.line_counter;

    if (end_of_text) begin
      has_result        = 1'b1;
      result.event_kind = (cur.phase == PH_LOW) ? EV_UNEXPECTED : EV_TEXT_END;
      result.byte_count = (cur.phase == PH_LOW) ? 9'd0 : cur.stored_count;
      nxt.phase         = PH_HIGH;
      nxt.upper_nibble  = 4'd0;
      nxt.stored_count  = 9'd0;
    end else begin
      case (cur.phase)
        PH_COMMENT: begin
          if (char_code == CH_LF) begin
            nxt.phase        = PH_HIGH;
            nxt.line_counter = line_inc;
          end
        end
        PH_LOW: begin
          if (nib_ok) begin
            nxt.phase = PH_HIGH;
            // A byte past the limit is dropped without a transaction.
            if (cur.stored_count < limit_eff) begin
              has_result        = 1'b1;
              result.event_kind = EV_BYTE;
              result.address    = cur.stored_count[7:0];
              result.data       = {cur.upper_nibble, nib};
              result.byte_count = cur.stored_count + 9'd1;
              nxt.stored_count  = cur.stored_count + 9'd1;
            end
          end else begin
            has_result        = 1'b1;
            result.event_kind = EV_SYNTAX;
            nxt.phase         = PH_HIGH;
            nxt.upper_nibble  = 4'd0;
            nxt.stored_count  = 9'd0;
          end
        end
        default: begin
          case (char_code)
            CH_COMMENT: begin
              nxt.phase = PH_COMMENT;
            end
            CH_END, CH_CLEAR, CH_REWIND: begin
              has_result        = 1'b1;
              result.event_kind = (char_code == CH_END)   ? EV_END :
                                  (char_code == CH_CLEAR) ? EV_END_CLEAR : EV_END_REWIND;
              result.byte_count = cur.stored_count;
              nxt.phase         = PH_HIGH;
              nxt.upper_nibble  = 4'd0;
              nxt.stored_count  = 9'd0;
            end
            CH_LF: begin
              nxt.line_counter = line_inc;
            end
            CH_CR, CH_SPACE, CH_TAB: begin
              nxt.phase = PH_HIGH;
            end
            default: begin
              if (nib_ok) begin
                nxt.upper_nibble = nib;
                nxt.phase        = PH_LOW;
              end else begin
                has_result        = 1'b1;
                result.event_kind = EV_SYNTAX;
                nxt.phase         = PH_HIGH;
                nxt.upper_nibble  = 4'd0;
                nxt.stored_count  = 9'd0;
              end
            end
          endcase
        end
      endcase
    end
  end

endmodule

FILE: hdl/hex_text_program_loader.sv
// Top level of the hex text program loader: parser state, configuration
// register, output register and skid stage. Depends on hexld_pkg, the
// channel interfaces in hexld_if.sv and hexld_step.
//
// Usage: program text enters on in_chan, one character per transaction, with
// end_of_text marking the end of the text. Pairs of hex digits become bytes
// that leave on out_chan as byte-written events carrying address, data and
// running count; end markers and text end leave as end events that carry the
// line and the byte count of the program just finished, errors as error events
// with the line and a zero count. The memory_limit register (byte address 0)
// caps the bytes stored per program; the user must write it over the APB port
// only while the loader is idle, which the block does not enforce. Throughput:
// one character per cycle while the skid stage is free, set by the single
// registered pass through the per-character logic.
// Reset: the parser expects a high nibble, the count is zero, the line is one
// and memory_limit is 256; both output stages are emptied.
// When the receiver stalls, one event waits in the output register and a
// second can land in the skid stage; only then does in_chan drop ready.
module hex_text_program_loader (
  input  logic                              clk,
  input  logic                              rst,
  hexld_in_if.sink                          in_chan,
  hexld_out_if.source                       out_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hexld_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import hexld_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [8:0] memory_limit;
  logic       has_result;
  result_t    step_result;
  logic       in_accept;
  logic       produce;

  logic       out_valid;
  result_t    out_res;
  logic       skid_valid;
  result_t    skid_res;

  // Configuration port: writes complete in the access cycle, never wait.
  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == REG_MEMORY_LIMIT) begin
      prdata = {23'd0, memory_limit};
    end else begin
      prdata = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_limit <= MEM_BYTES;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MEMORY_LIMIT) begin
      memory_limit <= pwdata[8:0];
    end
  end

  // Per-character logic works straight on the accepted transaction.
  hexld_step u_step (
    .cur          (state),
    .char_code    (in_chan.char_code),
    .end_of_text  (in_chan.end_of_text),
    .memory_limit (memory_limit),
    .nxt          (state_next),
    .has_result   (has_result),
    .result       (step_result)
  );

  // Input is taken whenever the skid stage is free, so a pending event in the
  // output register does not hold back the text stream.
  assign in_chan.ready = !skid_valid;
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign produce       = in_accept && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_HIGH;
      state.upper_nibble <= 4'd0;
      state.stored_count <= 9'd0;
      state.line_counter <= LINE_FIRST;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // Output register with a one-entry skid stage behind it. Events keep their
  // order: the skid entry always moves into the output register first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_chan.ready) begin
      if (produce) begin
        skid_valid <= 1'b1;
        skid_res   <= step_result;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      out_res    <= skid_res;
      skid_valid <= produce;
      if (produce) begin
        skid_res <= step_result;
      end
    end else begin
      out_valid <= produce;
      if (produce) begin
        out_res <= step_result;
      end
    end
  end

  assign out_chan.valid       = out_valid;
  assign out_chan.event_kind  = out_res.event_kind;
  assign out_chan.address     = out_res.address;
  assign out_chan.data        = out_res.data;
  assign out_chan.byte_count  = out_res.byte_count;
  assign out_chan.line_number = out_res.line_number;

endmodule
